// ===== rtl/core/tdsm_pkg.sv =====
// types, constants and font table shared by the display driver
package tdsm_pkg;

    localparam int CODE_W = 4;
    localparam int DIGITS = 3;

    typedef logic [CODE_W-1:0] code_t;
    typedef code_t [DIGITS-1:0] codes_t;

    localparam code_t CODE_BLANK = 4'd10;
    localparam code_t CODE_MINUS = 4'd11;

    localparam logic signed [15:0] CLAMP_HIGH = 16'sd999;
    localparam logic signed [15:0] CLAMP_LOW = -16'sd99;

    localparam logic [2:0] DP_MASK_RESET = 3'd0;
    localparam logic [15:0] REFRESH_RESET = 16'd1000;

    typedef enum logic [0:0] {
        CFG_DP_MASK = 1'b0,
        CFG_REFRESH_PERIOD = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [2:0] dp_mask;
        logic [15:0] refresh_period;
    } cfg_t;

    typedef struct packed {
        logic tick;
        logic load;
    } step_t;

    function automatic logic [6:0] font(input code_t code);
        logic [6:0] pat;
        begin
            case (code)
                4'd0: pat = 7'h3F;
                4'd1: pat = 7'h06;
                4'd2: pat = 7'h5B;
                4'd3: pat = 7'h4F;
                4'd4: pat = 7'h66;
                4'd5: pat = 7'h6D;
                4'd6: pat = 7'h7D;
                4'd7: pat = 7'h07;
                4'd8: pat = 7'h7F;
                4'd9: pat = 7'h6F;
                CODE_MINUS: pat = 7'h40;
                default: pat = 7'h00;
            endcase
            return pat;
        end
    endfunction

endpackage

// ===== rtl/core/tdsm_in_if.sv =====
// input item channel
interface tdsm_in_if;
    logic valid;
    logic ready;
    logic func;
    logic signed [15:0] number;

    modport source (output valid, output func, output number, input ready);
    modport sink (input valid, input func, input number, output ready);
endinterface

// ===== rtl/core/tdsm_out_if.sv =====
// result item channel
interface tdsm_out_if;
    logic valid;
    logic ready;
    logic [6:0] segments;
    logic point;
    logic [2:0] digit_enable;

    modport source (output valid, output segments, output point, output digit_enable,
                    input ready);
    modport sink (input valid, input segments, input point, input digit_enable,
                  output ready);
endinterface

// ===== rtl/core/tdsm_cfg_if.sv =====
// configuration write channel
interface tdsm_cfg_if;
    logic valid;
    logic ready;
    logic [0:0] index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/tdsm_split.sv =====
// clamps a number and splits it into digit codes with blanking and sign
module tdsm_split (
    input  logic signed [15:0] number,
    output tdsm_pkg::codes_t   codes
);

    logic signed [15:0] clamped;
    logic               neg;
    logic [9:0]         mag;
    logic [15:0]        h_prod;
    logic [3:0]         hundreds;
    logic [9:0]         rem_full;
    logic [6:0]         rem;
    logic [14:0]        t_prod;
    logic [3:0]         tens;
    logic [6:0]         ones_full;
    logic [3:0]         ones;
    logic [15:0]        neg_val;

    always_comb
    begin
        if (number > tdsm_pkg::CLAMP_HIGH)
        begin
            clamped = tdsm_pkg::CLAMP_HIGH;
        end
        else if (number < tdsm_pkg::CLAMP_LOW)
        begin
            clamped = tdsm_pkg::CLAMP_LOW;
        end
        else
        begin
            clamped = number;
        end
        neg = clamped[15];
        neg_val = 16'(-clamped);
        mag = neg ? neg_val[9:0] : clamped[9:0];
    end

    // divide by 100 and by 10 through reciprocal multiplies, exact below 1000
    always_comb
    begin
        h_prod = 16'(mag) * 16'd41;
        hundreds = h_prod[15:12];
        rem_full = mag - 10'(hundreds) * 10'd100;
        rem = rem_full[6:0];
        t_prod = 15'(rem) * 15'd205;
        tens = t_prod[14:11];
        ones_full = rem - 7'(tens) * 7'd10;
        ones = ones_full[3:0];
    end

    always_comb
    begin
        codes[2] = ones;
        if (neg)
        begin
            if (mag < 10'd10)
            begin
                codes[0] = tdsm_pkg::CODE_BLANK;
                codes[1] = tdsm_pkg::CODE_MINUS;
            end
            else
            begin
                codes[0] = tdsm_pkg::CODE_MINUS;
                codes[1] = tens;
            end
        end
        else
        begin
            codes[0] = (mag < 10'd100) ? tdsm_pkg::CODE_BLANK : hundreds;
            codes[1] = (mag < 10'd10) ? tdsm_pkg::CODE_BLANK : tens;
        end
    end

endmodule

// ===== rtl/core/tdsm_scan.sv =====
// digit store, refresh counter, scan position and latched drives
module tdsm_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  tdsm_pkg::step_t     step,
    input  tdsm_pkg::codes_t    new_codes,
    input  tdsm_pkg::cfg_t      cfg,
    output logic [7:0]          segment_drive,
    output logic [2:0]          digit_drive
);

    tdsm_pkg::codes_t codes_reg;
    tdsm_pkg::codes_t codes_next;
    logic [15:0]      count_reg;
    logic [15:0]      count_next;
    logic [1:0]       scan_pos_reg;
    logic [1:0]       scan_pos_next;
    logic [7:0]       seg_reg;
    logic [7:0]       seg_next;
    logic [2:0]       dig_reg;
    logic [2:0]       dig_next;
    logic [16:0]      count_inc;
    logic             refresh;
    logic [1:0]       pos;
    tdsm_pkg::code_t  code;

    always_comb
    begin
        count_inc = {1'b0, count_reg} + 17'd1;
        refresh = step.tick && (count_inc >= {1'b0, cfg.refresh_period});
        pos = (scan_pos_reg == 2'd3) ? 2'd0 : scan_pos_reg;
        code = codes_reg[pos];
    end

    always_comb
    begin
        codes_next = step.load ? new_codes : codes_reg;
        count_next = count_reg;
        scan_pos_next = scan_pos_reg;
        seg_next = seg_reg;
        dig_next = dig_reg;
        if (step.tick)
        begin
            count_next = refresh ? 16'd0 : count_inc[15:0];
        end
        if (refresh)
        begin
            seg_next = {cfg.dp_mask[pos], tdsm_pkg::font(code)};
            dig_next = 3'd1 << pos;
            scan_pos_next = (pos >= 2'd2) ? 2'd0 : 2'(pos + 2'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg <= {tdsm_pkg::CODE_BLANK, tdsm_pkg::CODE_BLANK, tdsm_pkg::CODE_BLANK};
            count_reg <= 16'd0;
            scan_pos_reg <= 2'd0;
            seg_reg <= 8'd0;
            dig_reg <= 3'd0;
        end
        else
        begin
            codes_reg <= codes_next;
            count_reg <= count_next;
            scan_pos_reg <= scan_pos_next;
            seg_reg <= seg_next;
            dig_reg <= dig_next;
        end
    end

    assign segment_drive = seg_reg;
    assign digit_drive = dig_reg;

    a_digit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(dig_reg))
        else $error("digit drive not one-hot");

    a_load_holds_drive: assert property (@(posedge clk) disable iff (!rst_n)
        step.load |=> $stable(seg_reg) && $stable(dig_reg))
        else $error("show item changed the drive");

    a_scan_follows_drive: assert property (@(posedge clk) disable iff (!rst_n)
        dig_reg[2] |-> scan_pos_reg == 2'd0)
        else $error("scan position out of step with drive");

    a_tick_only_on_own_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(step.tick && step.load))
        else $error("tick and load in one step");

endmodule

// ===== rtl/core/three_digit_seven_segment_mux_unit.sv =====
// top level of the three-digit multiplexed seven-segment driver
//
//  channel     dir   fields                              accepted when
//  item_in     in    func, number                        valid && ready
//  result_out  out   segments, point, digit_enable       valid && ready
//  cfg         in    index (0 dp_mask, 1 period), data   valid && ready
//
//  one result per item
//  an item is accepted every cycle unless a stalled result keeps the input register full;
//  input register and drive register form the two stages, so a stalled result holds only one item back
//  reset blanks all digits, clears counter, scan position and drives,
//  sets period to 1000 and the point mask to zero
//  cfg is always ready
module three_digit_seven_segment_mux_unit (
    input  logic        clk,
    input  logic        rst_n,
    tdsm_in_if.sink     item_in,
    tdsm_out_if.source  result_out,
    tdsm_cfg_if.sink    cfg
);

    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_func_reg;
    logic signed [15:0] s1_number_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               s1_advance;
    logic               in_fire;
    tdsm_pkg::cfg_t     cfg_reg;
    tdsm_pkg::step_t    step;
    tdsm_pkg::codes_t   new_codes;
    logic [7:0]         segment_drive;
    logic [2:0]         digit_drive;

    assign s1_advance = !out_valid_reg || result_out.ready;
    assign item_in.ready = !s1_valid_reg || s1_advance;
    assign in_fire = item_in.valid && item_in.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        step.tick = s1_valid_reg && s1_advance && !s1_func_reg;
        step.load = s1_valid_reg && s1_advance && s1_func_reg;
        s1_valid_next = in_fire ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_advance ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg.dp_mask <= tdsm_pkg::DP_MASK_RESET;
            cfg_reg.refresh_period <= tdsm_pkg::REFRESH_RESET;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    tdsm_pkg::CFG_DP_MASK: cfg_reg.dp_mask <= cfg.data[2:0];
                    tdsm_pkg::CFG_REFRESH_PERIOD: cfg_reg.refresh_period <= cfg.data;
                    default: cfg_reg <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg <= item_in.func;
            s1_number_reg <= item_in.number;
        end
    end

    tdsm_split u_split (
        .number (s1_number_reg),
        .codes  (new_codes)
    );

    tdsm_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .new_codes     (new_codes),
        .cfg           (cfg_reg),
        .segment_drive (segment_drive),
        .digit_drive   (digit_drive)
    );

    assign result_out.valid = out_valid_reg;
    assign result_out.segments = segment_drive[6:0];
    assign result_out.point = segment_drive[7];
    assign result_out.digit_enable = digit_drive;

    a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_advance |=> s1_valid_reg)
        else $error("waiting item dropped");

    a_result_follows_item: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_advance |=> out_valid_reg)
        else $error("item advanced without result");

    a_no_result_without_item: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && !s1_valid_reg |=> !out_valid_reg)
        else $error("result without item");

endmodule

// ===== dv/three_digit_seven_segment_mux_unit_tb.sv =====
// testbench for three_digit_seven_segment_mux_unit: random and directed items against a predictor

typedef struct packed {
    logic [6:0] segments;
    logic       point;
    logic [2:0] digit_enable;
} drive_t;

class display_scoreboard;
    tdsm_pkg::code_t digits [tdsm_pkg::DIGITS];
    logic [6:0]      glyph [16];
    logic [16:0]     tick_count;
    logic [1:0]      scan_pos;
    logic [7:0]      seg_latch;
    logic [2:0]      dig_latch;
    logic [2:0]      point_mask;
    logic [15:0]     period;
    drive_t          drive_queue [$];
    int              mismatches;

    function new();
        foreach (glyph[i])
            glyph[i] = 7'h00;
        glyph[0] = 7'h3F;
        glyph[1] = 7'h06;
        glyph[2] = 7'h5B;
        glyph[3] = 7'h4F;
        glyph[4] = 7'h66;
        glyph[5] = 7'h6D;
        glyph[6] = 7'h7D;
        glyph[7] = 7'h07;
        glyph[8] = 7'h7F;
        glyph[9] = 7'h6F;
        glyph[tdsm_pkg::CODE_MINUS] = 7'h40;
        foreach (digits[i])
            digits[i] = tdsm_pkg::CODE_BLANK;
        tick_count = '0;
        scan_pos = '0;
        seg_latch = '0;
        dig_latch = '0;
        point_mask = tdsm_pkg::DP_MASK_RESET;
        period = tdsm_pkg::REFRESH_RESET;
        mismatches = 0;
    endfunction

    function void write_reg(tdsm_pkg::cfg_index_t idx, logic [15:0] data);
        case (idx)
            tdsm_pkg::CFG_DP_MASK: point_mask = data[2:0];
            tdsm_pkg::CFG_REFRESH_PERIOD: period = data;
            default: ;
        endcase
    endfunction

    function void show_number(logic signed [15:0] raw);
        int v;
        int mag;
        v = raw;
        if (v > 999)
            v = 999;
        if (v < -99)
            v = -99;
        if (v < 0)
        begin
            mag = -v;
            if (mag < 10)
            begin
                digits[0] = tdsm_pkg::CODE_BLANK;
                digits[1] = tdsm_pkg::CODE_MINUS;
            end
            else
            begin
                digits[0] = tdsm_pkg::CODE_MINUS;
                digits[1] = tdsm_pkg::code_t'(mag / 10);
            end
            digits[2] = tdsm_pkg::code_t'(mag % 10);
        end
        else
        begin
            mag = v;
            digits[0] = (mag < 100) ? tdsm_pkg::CODE_BLANK : tdsm_pkg::code_t'(mag / 100);
            digits[1] = (mag < 10) ? tdsm_pkg::CODE_BLANK : tdsm_pkg::code_t'((mag / 10) % 10);
            digits[2] = tdsm_pkg::code_t'(mag % 10);
        end
    endfunction

    function void latch_digit();
        logic [1:0]      pos;
        tdsm_pkg::code_t code;
        pos = (scan_pos < 2'd3) ? scan_pos : 2'd0;
        code = digits[pos];
        seg_latch = {point_mask[pos], (code < 4'd12) ? glyph[code] : 7'h00};
        dig_latch = 3'b001 << pos;
        scan_pos = (pos >= 2'd2) ? 2'd0 : pos + 2'd1;
    endfunction

    function void note_item(logic func, logic signed [15:0] number);
        drive_t d;
        if (func)
            show_number(number);
        else
        begin
            tick_count = tick_count + 17'd1;
            if (tick_count >= {1'b0, period})
            begin
                tick_count = '0;
                latch_digit();
            end
        end
        d.segments = seg_latch[6:0];
        d.point = seg_latch[7];
        d.digit_enable = dig_latch;
        drive_queue.push_back(d);
    endfunction

    function void check_result(drive_t got);
        drive_t want;
        if (drive_queue.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: segments %h point %b enable %b",
                         got.segments, got.point, got.digit_enable);
            return;
        end
        want = drive_queue.pop_front();
        if (got.segments !== want.segments || got.point !== want.point ||
            got.digit_enable !== want.digit_enable)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: segments %h/%h point %b/%b enable %b/%b (expected/actual)",
                         want.segments, got.segments, want.point, got.point,
                         want.digit_enable, got.digit_enable);
        end
    endfunction

    function int pending();
        return drive_queue.size();
    endfunction
endclass

module three_digit_seven_segment_mux_unit_tb;

    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD = 60;
    localparam int PHASE_ITEMS = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cycles = 0;
    bit   tx_gaps = 1'b1;
    bit   rx_gaps = 1'b1;
    bit   long_hold = 1'b0;

    display_scoreboard sb = new();

    tdsm_in_if  item_if ();
    tdsm_out_if result_if ();
    tdsm_cfg_if cfg_if ();

    three_digit_seven_segment_mux_unit u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (result_if),
        .cfg        (cfg_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("three_digit_seven_segment_mux_unit regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
                sb.check_result({result_if.segments, result_if.point, result_if.digit_enable});
            if (item_if.valid && item_if.ready)
                sb.note_item(item_if.func, item_if.number);
            if (cfg_if.valid && cfg_if.ready)
                sb.write_reg(tdsm_pkg::cfg_index_t'(cfg_if.index), cfg_if.data);
        end
    end

    // result side
    initial
    begin
        int wait_n;
        result_if.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                result_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            wait_n = rx_gaps ? $urandom_range(0, 15) : 0;
            if (wait_n > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do @(posedge clk); while (!result_if.valid);
        end
    end

    task automatic send_item(input logic func, input logic signed [15:0] number);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.func <= func;
        item_if.number <= number;
        do @(posedge clk); while (!item_if.ready);
    endtask

    task automatic ticks(input int n);
        repeat (n) send_item(1'b0, 16'($urandom));
    endtask

    task automatic drain();
        item_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_config(input logic [2:0] mask, input logic [15:0] refresh);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= tdsm_pkg::CFG_DP_MASK;
        cfg_if.data <= {13'($urandom), mask};
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.index <= tdsm_pkg::CFG_REFRESH_PERIOD;
        cfg_if.data <= refresh;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [15:0]        periods [7];
        logic [2:0]         mask;
        logic               func;
        logic signed [15:0] number;
        logic signed [15:0] edges [12];

        periods = '{16'd1, 16'd0, 16'd2, 16'd3, 16'd1, 16'd65535, 16'd1};
        edges = '{-16'sd100, -16'sd99, -16'sd10, -16'sd9, -16'sd1, 16'sd0,
                  16'sd9, 16'sd10, 16'sd99, 16'sd100, 16'sd999, 16'sd1000};
        item_if.valid <= 1'b0;
        item_if.func <= 1'b0;
        item_if.number <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= tdsm_pkg::CFG_DP_MASK;
        cfg_if.data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no refresh yet, drives stay dark
        send_item(1'b1, 16'sd123);
        ticks(3);
        drain();

        set_config(3'b101, 16'd1);
        send_item(1'b1, 16'sd32767);
        ticks(3);
        send_item(1'b1, -16'sd32768);
        ticks(3);
        send_item(1'b1, -16'sd5);
        ticks(3);
        send_item(1'b1, 16'sd0);
        ticks(3);
        send_item(1'b1, 16'sd100);
        ticks(1);
        drain();

        // period dropped below the running count
        set_config(3'b111, 16'd65535);
        ticks(3);
        drain();
        set_config(3'b111, 16'd2);
        ticks(1);
        drain();

        // zero period
        set_config(3'b010, 16'd0);
        ticks(2);
        drain();

        for (int p = 0; p < 7; p++)
        begin
            mask = (p == 1) ? 3'b000 : (p == 2) ? 3'b111 : 3'($urandom);
            if (p == 4)
                periods[p] = 16'($urandom_range(1, 8));
            set_config(mask, periods[p]);
            tx_gaps = (p % 3 != 1);
            rx_gaps = (p % 2 == 0);
            if (p == 1 || p == 4)
                long_hold = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                func = ($urandom_range(0, 3) == 0);
                case ($urandom_range(0, 3))
                    0: number = 16'($urandom);
                    1: number = 16'($signed($urandom_range(0, 1250)) - 150);
                    default: number = edges[$urandom_range(0, 11)];
                endcase
                send_item(func, number);
            end
            drain();
        end

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("three_digit_seven_segment_mux_unit regression: pass");
        else
            $display("three_digit_seven_segment_mux_unit regression: fail");
        $finish;
    end
endmodule
